// ----- sv/rpbb_pkg.sv -----
// Shared types and constants for the rotated point bounding box block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rpbb_pkg;

   localparam int COORD_WIDTH       = 16;
   localparam int COEF_WIDTH        = 16;
   localparam int COEF_FRAC_BITS    = 14;
   localparam int ROT_WIDTH         = 18;
   localparam int AXIS_COUNT        = 3;
   localparam int CSR_WIDTH         = AXIS_COUNT * COEF_WIDTH;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int PROD_WIDTH        = COORD_WIDTH + COEF_WIDTH;
   localparam int SUM_WIDTH         = PROD_WIDTH + 2;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = QUEUE_PTR_WIDTH + 1;
   localparam int FRONT_STAGES      = 2;
   localparam int FRONT_COUNT_WIDTH = $clog2(FRONT_STAGES + 1);

   localparam logic signed [ROT_WIDTH-1:0] ROT_MAX = {1'b0, {(ROT_WIDTH-1){1'b1}}};
   localparam logic signed [ROT_WIDTH-1:0] ROT_MIN = {1'b1, {(ROT_WIDTH-1){1'b0}}};

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AXIS_ONE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AXIS_TWO   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AXIS_THREE = 2'd2;

   localparam logic [CSR_WIDTH-1:0] AXIS_ONE_RESET   = 48'h0000_0000_4000;
   localparam logic [CSR_WIDTH-1:0] AXIS_TWO_RESET   = 48'h0000_4000_0000;
   localparam logic [CSR_WIDTH-1:0] AXIS_THREE_RESET = 48'h4000_0000_0000;

   typedef logic signed [ROT_WIDTH-1:0] rot_type;

   typedef struct packed {
      rot_type rot_x;
      rot_type rot_y;
      rot_type rot_z;
      logic    cloud_end;
   } rot_word_type;

   typedef struct packed {
      rot_type min_x;
      rot_type max_x;
      rot_type min_y;
      rot_type max_y;
      rot_type min_z;
      rot_type max_z;
   } box_word_type;

endpackage

`default_nettype wire

// ----- sv/rpbb_front.sv -----
// Front end: frame registers, point capture and rotation into the frame.
// Two stages: nine coefficient products, then sum, floor shift and saturation.
// Depends on rpbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpbb_front
   import rpbb_pkg::*;
(
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0]        csr_index,
   input  wire logic [CSR_WIDTH-1:0]              csr_data,
   input  wire logic                              accept,
   input  wire logic signed [COORD_WIDTH-1:0]     coord_x,
   input  wire logic signed [COORD_WIDTH-1:0]     coord_y,
   input  wire logic signed [COORD_WIDTH-1:0]     coord_z,
   input  wire logic                              cloud_end,
   output logic                                   word_valid,
   output rot_word_type                           word,
   output logic [FRONT_COUNT_WIDTH-1:0]           inflight
);

   logic [CSR_WIDTH-1:0] frame_ff [AXIS_COUNT];

   logic signed [COORD_WIDTH-1:0] coord_vec [AXIS_COUNT];
   logic signed [PROD_WIDTH-1:0]  prod_in   [AXIS_COUNT][AXIS_COUNT];
   logic signed [PROD_WIDTH-1:0]  prod_ff   [AXIS_COUNT][AXIS_COUNT];
   logic                          prod_valid_ff;
   logic                          prod_end_ff;

   logic signed [SUM_WIDTH-1:0]   sum_vec   [AXIS_COUNT];
   logic signed [SUM_WIDTH-1:0]   shift_vec [AXIS_COUNT];
   rot_type                       rot_in    [AXIS_COUNT];
   rot_type                       rot_ff    [AXIS_COUNT];
   logic                          rot_valid_ff;
   logic                          rot_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff[0] <= AXIS_ONE_RESET;
         frame_ff[1] <= AXIS_TWO_RESET;
         frame_ff[2] <= AXIS_THREE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_AXIS_ONE:   frame_ff[0] <= csr_data;
            CSR_AXIS_TWO:   frame_ff[1] <= csr_data;
            CSR_AXIS_THREE: frame_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      coord_vec[0] = coord_x;
      coord_vec[1] = coord_y;
      coord_vec[2] = coord_z;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         for (int c = 0; c < AXIS_COUNT; c++) begin
            prod_in[a][c] = PROD_WIDTH'(signed'(frame_ff[a][c*COEF_WIDTH +: COEF_WIDTH]))
                          * PROD_WIDTH'(coord_vec[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff     <= prod_in;
         prod_end_ff <= cloud_end;
      end
   end

   always_comb begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
         sum_vec[a] = SUM_WIDTH'(prod_ff[a][0]) + SUM_WIDTH'(prod_ff[a][1])
                    + SUM_WIDTH'(prod_ff[a][2]);
         shift_vec[a] = sum_vec[a] >>> COEF_FRAC_BITS;
         if (shift_vec[a] > SUM_WIDTH'(ROT_MAX)) begin
            rot_in[a] = ROT_MAX;
         end else if (shift_vec[a] < SUM_WIDTH'(ROT_MIN)) begin
            rot_in[a] = ROT_MIN;
         end else begin
            rot_in[a] = shift_vec[a][ROT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_valid_ff <= 1'b0;
      end else begin
         rot_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_valid_ff) begin
         rot_ff     <= rot_in;
         rot_end_ff <= prod_end_ff;
      end
   end

   assign word_valid     = rot_valid_ff;
   assign word.rot_x     = rot_ff[0];
   assign word.rot_y     = rot_ff[1];
   assign word.rot_z     = rot_ff[2];
   assign word.cloud_end = rot_end_ff;
   assign inflight       = FRONT_COUNT_WIDTH'(prod_valid_ff) + FRONT_COUNT_WIDTH'(rot_valid_ff);

endmodule

`default_nettype wire

// ----- sv/rpbb_queue.sv -----
// Short queue of rotated words between front and back end.
// Space is reserved for words still in the front pipeline. Depends on rpbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpbb_queue
   import rpbb_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire rot_word_type                 push_word,
   input  wire logic [FRONT_COUNT_WIDTH-1:0] inflight,
   output logic                              full,
   input  wire logic                         pop,
   output logic                              empty,
   output rot_word_type                      head_word
);

   rot_word_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]    wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0]    rd_ptr_ff;
   logic [QUEUE_COUNT_WIDTH-1:0]  count_ff;
   logic [QUEUE_COUNT_WIDTH-1:0]  count_in;
   logic [QUEUE_COUNT_WIDTH:0]    reserved;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign reserved  = (QUEUE_COUNT_WIDTH+1)'(count_ff) + (QUEUE_COUNT_WIDTH+1)'(inflight);
   assign full      = reserved >= (QUEUE_COUNT_WIDTH+1)'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_word = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- sv/rpbb_back.sv -----
// Back end: running min/max trackers per axis and a two-word result buffer.
// Consumes rotated words from rpbb_queue. Depends on rpbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpbb_back
   import rpbb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         word_ready,
   input  wire rot_word_type word,
   output logic              word_pop,
   input  wire logic         rsp_pop,
   output logic              rsp_empty,
   output box_word_type      rsp_word
);

   localparam int OUT_DEPTH = 2;

   rot_type      min_ff [AXIS_COUNT];
   rot_type      max_ff [AXIS_COUNT];
   rot_type      min_in [AXIS_COUNT];
   rot_type      max_in [AXIS_COUNT];
   rot_type      val    [AXIS_COUNT];
   box_word_type box_in;

   box_word_type out_ff [OUT_DEPTH];
   logic         out_wr_ff;
   logic         out_rd_ff;
   logic [1:0]   out_count_ff;
   logic         out_push;
   logic         out_pop;

   assign val[0] = word.rot_x;
   assign val[1] = word.rot_y;
   assign val[2] = word.rot_z;

   always_comb begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
         min_in[a] = (val[a] < min_ff[a]) ? val[a] : min_ff[a];
         max_in[a] = (val[a] > max_ff[a]) ? val[a] : max_ff[a];
      end
   end

   assign box_in = '{min_x: min_in[0], max_x: max_in[0],
                     min_y: min_in[1], max_y: max_in[1],
                     min_z: min_in[2], max_z: max_in[2]};

   assign word_pop = word_ready && (!word.cloud_end || out_count_ff < 2'(OUT_DEPTH));
   assign out_push = word_pop && word.cloud_end;
   assign out_pop  = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXIS_COUNT; a++) begin
            min_ff[a] <= ROT_MAX;
            max_ff[a] <= ROT_MIN;
         end
      end else if (word_pop) begin
         for (int a = 0; a < AXIS_COUNT; a++) begin
            min_ff[a] <= word.cloud_end ? ROT_MAX : min_in[a];
            max_ff[a] <= word.cloud_end ? ROT_MIN : max_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= '0;
      end else begin
         if (out_push) begin
            out_wr_ff <= ~out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= ~out_rd_ff;
         end
         if (out_push && !out_pop) begin
            out_count_ff <= out_count_ff + 1'b1;
         end else if (out_pop && !out_push) begin
            out_count_ff <= out_count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wr_ff] <= box_in;
      end
   end

   assign rsp_empty = out_count_ff == '0;
   assign rsp_word  = out_ff[out_rd_ff];

endmodule

`default_nettype wire

// ----- sv/rotated_point_bounding_box_top.sv -----
// Rotated point bounding box: top level.
// Instantiates rpbb_front, rpbb_queue and rpbb_back; depends on rpbb_pkg.
//
// Usage:
//  - Points enter as queue pushes: req_push with req_coord_x/y/z and req_cloud_end,
//    taken at an edge where req_full is low. One point per cycle is sustained while req_full stays low.
//  - Each point is rotated by the three frame columns (csr indexes 0..2) and
//    folded into per-axis running min/max trackers.
//  - A point with req_cloud_end set closes the cloud: one box word (six limits,
//    that point included) is queued and the trackers restart.
//  - Results are read as a queue: while rsp_empty is low the oldest box is on
//    rsp_box_*; rsp_pop takes it.
//  - The closing point's box passes the product stage, the sum/saturate stage, the
//    front-to-back queue and the result buffer before it is visible on rsp_box_*.
//  - Throughput: 1 point per cycle while req_full stays low, set by the two-stage
//    multiply/sum pipeline and a single tracker update per cycle.
//  - If rsp_pop stays low the two-word result buffer fills, the back end stops on
//    the next closing point, the 4-word queue fills and req_full rises; no word is
//    lost. Non-closing points keep flowing while a result waits.
//  - csr writes are always taken (csr_ready high); write only while idle.
//  - Reset (synchronous): identity frame, empty queues, trackers cleared.
`timescale 1ns / 1ps
`default_nettype none

module rotated_point_bounding_box_top
   import rpbb_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [CSR_WIDTH-1:0]          csr_data,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_coord_z,
   input  wire logic                          req_cloud_end,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic signed [ROT_WIDTH-1:0]        rsp_box_min_x,
   output logic signed [ROT_WIDTH-1:0]        rsp_box_max_x,
   output logic signed [ROT_WIDTH-1:0]        rsp_box_min_y,
   output logic signed [ROT_WIDTH-1:0]        rsp_box_max_y,
   output logic signed [ROT_WIDTH-1:0]        rsp_box_min_z,
   output logic signed [ROT_WIDTH-1:0]        rsp_box_max_z
);

   logic                         accept;
   logic                         front_valid;
   rot_word_type                 front_word;
   logic [FRONT_COUNT_WIDTH-1:0] inflight;
   logic                         queue_empty;
   rot_word_type                 queue_head;
   logic                         queue_pop;
   box_word_type                 box_word;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   rpbb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .accept     (accept),
      .coord_x    (req_coord_x),
      .coord_y    (req_coord_y),
      .coord_z    (req_coord_z),
      .cloud_end  (req_cloud_end),
      .word_valid (front_valid),
      .word       (front_word),
      .inflight   (inflight)
   );

   rpbb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_word (front_word),
      .inflight  (inflight),
      .full      (req_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .head_word (queue_head)
   );

   rpbb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .word_ready (!queue_empty),
      .word       (queue_head),
      .word_pop   (queue_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_word   (box_word)
   );

   assign rsp_box_min_x = box_word.min_x;
   assign rsp_box_max_x = box_word.max_x;
   assign rsp_box_min_y = box_word.min_y;
   assign rsp_box_max_y = box_word.max_y;
   assign rsp_box_min_z = box_word.min_z;
   assign rsp_box_max_z = box_word.max_z;

endmodule

`default_nettype wire

// ----- tb/rotated_point_bounding_box_top_tb.sv -----
// Testbench for rotated_point_bounding_box_top: a directed table, then random point clouds
// under a series of frames; each box checked against the table or a behavioral box model.
// Depends on rpbb_pkg and the RTL of the block; self-contained otherwise.
`timescale 1ns / 1ps

module rotated_point_bounding_box_top_tb;
   import rpbb_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASES          = 8;
   localparam int POINTS_PER_PHASE = 125;
   localparam int PRESSURE_POINTS = 40;
   localparam int LONG_HOLD       = 300;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] AXIS_CODE [AXIS_COUNT] =
      '{CSR_AXIS_ONE, CSR_AXIS_TWO, CSR_AXIS_THREE};

   typedef struct {
      bit                             is_csr;
      logic [CSR_INDEX_WIDTH-1:0]     index;
      logic [CSR_WIDTH-1:0]           data;
      logic signed [COORD_WIDTH-1:0]  x;
      logic signed [COORD_WIDTH-1:0]  y;
      logic signed [COORD_WIDTH-1:0]  z;
      logic                           last;
      bit                             typed;
      box_word_type                   box;
   } script_row_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index;
   logic [CSR_WIDTH-1:0]          csr_data;
   logic                          req_push;
   logic                          req_full;
   logic signed [COORD_WIDTH-1:0] req_coord_x;
   logic signed [COORD_WIDTH-1:0] req_coord_y;
   logic signed [COORD_WIDTH-1:0] req_coord_z;
   logic                          req_cloud_end;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic signed [ROT_WIDTH-1:0]   rsp_box_min_x;
   logic signed [ROT_WIDTH-1:0]   rsp_box_max_x;
   logic signed [ROT_WIDTH-1:0]   rsp_box_min_y;
   logic signed [ROT_WIDTH-1:0]   rsp_box_max_y;
   logic signed [ROT_WIDTH-1:0]   rsp_box_min_z;
   logic signed [ROT_WIDTH-1:0]   rsp_box_max_z;

   logic [CSR_WIDTH-1:0] frame_col [AXIS_COUNT];
   rot_type              track_lo  [AXIS_COUNT];
   rot_type              track_hi  [AXIS_COUNT];
   box_word_type         boxes_due [$];
   script_row_type       script    [$];

   int mismatches    = 0;
   int cycle_count   = 0;
   int hold_requests = 0;
   int holds_done    = 0;
   int pop_hold      = 0;
   int pop_mode_age  = 0;
   bit pop_steady    = 1'b0;

   rotated_point_bounding_box_top uut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_coord_z   (req_coord_z),
      .req_cloud_end (req_cloud_end),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_box_min_x (rsp_box_min_x),
      .rsp_box_max_x (rsp_box_max_x),
      .rsp_box_min_y (rsp_box_min_y),
      .rsp_box_max_y (rsp_box_max_y),
      .rsp_box_min_z (rsp_box_min_z),
      .rsp_box_max_z (rsp_box_max_z)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rotated_point_bounding_box_top_tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- box model

   function automatic rot_type rotate_onto(input logic [CSR_WIDTH-1:0] col,
                                           input logic signed [COORD_WIDTH-1:0] x,
                                           input logic signed [COORD_WIDTH-1:0] y,
                                           input logic signed [COORD_WIDTH-1:0] z);
      longint cx;
      longint cy;
      longint cz;
      longint acc;
      cx  = longint'($signed(col[COEF_WIDTH-1:0]));
      cy  = longint'($signed(col[2*COEF_WIDTH-1:COEF_WIDTH]));
      cz  = longint'($signed(col[3*COEF_WIDTH-1:2*COEF_WIDTH]));
      // arithmetic shift floors toward minus infinity
      acc = (cx * longint'(x) + cy * longint'(y) + cz * longint'(z)) >>> COEF_FRAC_BITS;
      if (acc > longint'(ROT_MAX)) return ROT_MAX;
      if (acc < longint'(ROT_MIN)) return ROT_MIN;
      return rot_type'(acc);
   endfunction

   function automatic void clear_trackers();
      for (int a = 0; a < AXIS_COUNT; a++) begin
         track_lo[a] = ROT_MAX;
         track_hi[a] = ROT_MIN;
      end
   endfunction

   function automatic void set_frame(input logic [CSR_INDEX_WIDTH-1:0] index,
                                     input logic [CSR_WIDTH-1:0] data);
      case (index)
         CSR_AXIS_ONE:   frame_col[0] = data;
         CSR_AXIS_TWO:   frame_col[1] = data;
         CSR_AXIS_THREE: frame_col[2] = data;
         default: ;
      endcase
   endfunction

   task automatic fold_point(input logic signed [COORD_WIDTH-1:0] x,
                             input logic signed [COORD_WIDTH-1:0] y,
                             input logic signed [COORD_WIDTH-1:0] z,
                             input logic last);
      rot_type      r;
      box_word_type closed;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         r = rotate_onto(frame_col[a], x, y, z);
         if (r < track_lo[a]) track_lo[a] = r;
         if (r > track_hi[a]) track_hi[a] = r;
      end
      if (last) begin
         closed    = '{track_lo[0], track_hi[0], track_lo[1], track_hi[1],
                       track_lo[2], track_hi[2]};
         boxes_due = {boxes_due, closed};
         clear_trackers();
      end
   endtask

   // ---------------------------------------------------------------- result side

   task automatic check_limit(input string name, input rot_type want, input rot_type got);
      if (want !== got) begin
         $display("%0t box %s mismatch: expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      box_word_type want;
      int r;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (boxes_due.size() == 0) begin
               $display("%0t unexpected box word: expected none, got %0d %0d %0d %0d %0d %0d",
                        $time, rsp_box_min_x, rsp_box_max_x, rsp_box_min_y,
                        rsp_box_max_y, rsp_box_min_z, rsp_box_max_z);
               mismatches++;
            end else begin
               want = boxes_due.pop_front();
               check_limit("min_x", want.min_x, rsp_box_min_x);
               check_limit("max_x", want.max_x, rsp_box_max_x);
               check_limit("min_y", want.min_y, rsp_box_min_y);
               check_limit("max_y", want.max_y, rsp_box_max_y);
               check_limit("min_z", want.min_z, rsp_box_min_z);
               check_limit("max_z", want.max_z, rsp_box_max_z);
            end
         end
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            pop_hold   = LONG_HOLD;
         end else if (pop_hold == 0 && !pop_steady) begin
            r = $urandom_range(0, 99);
            if (r < 20)      pop_hold = $urandom_range(1, 3);
            else if (r < 23) pop_hold = $urandom_range(10, 60);
         end
         if (pop_hold != 0) begin
            pop_hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
         pop_mode_age++;
         if (pop_mode_age == 150) begin
            pop_mode_age = 0;
            pop_steady   = ($urandom_range(0, 3) == 0);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus side

   task automatic push_point(input logic signed [COORD_WIDTH-1:0] x,
                             input logic signed [COORD_WIDTH-1:0] y,
                             input logic signed [COORD_WIDTH-1:0] z,
                             input logic last,
                             input bit typed,
                             input box_word_type typed_box);
      req_push      <= 1'b1;
      req_coord_x   <= x;
      req_coord_y   <= y;
      req_coord_z   <= z;
      req_cloud_end <= last;
      do @(posedge clock); while (req_full);
      fold_point(x, y, z, last);
      if (last && typed) begin
         void'(boxes_due.pop_back());
         boxes_due = {boxes_due, typed_box};
      end
   endtask

   task automatic idle_sender(input bit steady);
      int r;
      int gap;
      r   = $urandom_range(0, 99);
      gap = 0;
      if (!steady) begin
         if (r < 5)       gap = $urandom_range(10, 40);
         else if (r < 30) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      req_push <= 1'b0;
      while (boxes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame(input logic [CSR_INDEX_WIDTH-1:0] index,
                              input logic [CSR_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      set_frame(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_frame(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_WIDTH-1:0] data);
      script_row_type row;
      row.is_csr = 1'b1;
      row.index  = index;
      row.data   = data;
      row.x      = '0;
      row.y      = '0;
      row.z      = '0;
      row.last   = 1'b0;
      row.typed  = 1'b0;
      row.box    = '0;
      script     = {script, row};
   endtask

   task automatic add_point(input logic signed [COORD_WIDTH-1:0] x,
                            input logic signed [COORD_WIDTH-1:0] y,
                            input logic signed [COORD_WIDTH-1:0] z,
                            input logic last,
                            input bit typed,
                            input box_word_type box);
      script_row_type row;
      row.is_csr = 1'b0;
      row.index  = '0;
      row.data   = '0;
      row.x      = x;
      row.y      = y;
      row.z      = z;
      row.last   = last;
      row.typed  = typed;
      row.box    = box;
      script     = {script, row};
   endtask

   function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
      if ($urandom_range(0, 9) != 0) return COORD_WIDTH'($urandom);
      case ($urandom_range(0, 4))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return 16'sh0001;
      endcase
   endfunction

   function automatic logic [COEF_WIDTH-1:0] pick_extreme_coef();
      case ($urandom_range(0, 4))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'h4000;
         default: return 16'hC000;
      endcase
   endfunction

   function automatic logic [CSR_WIDTH-1:0] pick_column(input int style, input int axis);
      logic [CSR_WIDTH-1:0] col;
      case (style)
         0: col = CSR_WIDTH'({$urandom, $urandom});
         1: begin
            // moderate coefficients, within +-1.0
            for (int k = 0; k < AXIS_COUNT; k++)
               col[k*COEF_WIDTH +: COEF_WIDTH] = COEF_WIDTH'($urandom_range(0, 32768) - 16384);
         end
         2: begin
            for (int k = 0; k < AXIS_COUNT; k++)
               col[k*COEF_WIDTH +: COEF_WIDTH] = pick_extreme_coef();
         end
         default: begin
            col = (axis == 0) ? AXIS_ONE_RESET : (axis == 1) ? AXIS_TWO_RESET : AXIS_THREE_RESET;
         end
      endcase
      return col;
   endfunction

   initial begin
      int           cloud_left;
      bit           steady;
      logic         last;
      box_word_type none;

      none          = '0;
      cloud_left    = 0;
      reset         <= 1'b1;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_data      <= '0;
      req_push      <= 1'b0;
      req_coord_x   <= '0;
      req_coord_y   <= '0;
      req_coord_z   <= '0;
      req_cloud_end <= 1'b0;
      frame_col[0]  = AXIS_ONE_RESET;
      frame_col[1]  = AXIS_TWO_RESET;
      frame_col[2]  = AXIS_THREE_RESET;
      clear_trackers();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity frame after reset
      add_point(16'sh7FFF, 16'sh8000, 0, 1'b1, 1'b1, '{32767, 32767, -32768, -32768, 0, 0});
      add_point(16'sh8000, 16'sh7FFF, -1, 1'b1, 1'b1, '{-32768, -32768, 32767, 32767, -1, -1});
      add_point(0, 0, 0, 1'b1, 1'b1, '{0, 0, 0, 0, 0, 0});
      add_point(-1, -1, -1, 1'b0, 1'b0, none);
      add_point(1, 1, 1, 1'b0, 1'b0, none);
      add_point(100, -200, 300, 1'b1, 1'b1, '{-1, 100, -200, 1, -1, 300});
      // largest positive coefficients saturate
      add_frame(CSR_AXIS_ONE,   48'h7FFF_7FFF_7FFF);
      add_frame(CSR_AXIS_TWO,   48'h7FFF_7FFF_7FFF);
      add_frame(CSR_AXIS_THREE, 48'h7FFF_7FFF_7FFF);
      add_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1,
                '{ROT_MAX, ROT_MAX, ROT_MAX, ROT_MAX, ROT_MAX, ROT_MAX});
      add_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b1,
                '{ROT_MIN, ROT_MIN, ROT_MIN, ROT_MIN, ROT_MIN, ROT_MIN});
      // most negative coefficients
      add_frame(CSR_AXIS_ONE,   48'h8000_8000_8000);
      add_frame(CSR_AXIS_TWO,   48'h8000_8000_8000);
      add_frame(CSR_AXIS_THREE, 48'h8000_8000_8000);
      add_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b1,
                '{ROT_MAX, ROT_MAX, ROT_MAX, ROT_MAX, ROT_MAX, ROT_MAX});
      add_point(12345, -321, 7, 1'b0, 1'b0, none);
      add_point(-5, 6000, -7000, 1'b1, 1'b0, none);
      // tiny coefficients: shift rounds toward minus infinity
      add_frame(CSR_AXIS_ONE,   48'h0000_0000_0001);
      add_frame(CSR_AXIS_TWO,   48'h0000_0000_0000);
      add_frame(CSR_AXIS_THREE, 48'hFFFF_FFFF_FFFF);
      add_point(-1, 0, 0, 1'b1, 1'b1, '{-1, -1, 0, 0, 0, 0});
      // unmapped index leaves the frame alone
      add_frame(CSR_UNUSED,     48'h7FFF_7FFF_7FFF);
      add_point(1, 0, 0, 1'b1, 1'b1, '{0, 0, 0, 0, -1, -1});
      add_point(3, 4, 5, 1'b0, 1'b0, none);

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            drain_pipeline();
            write_frame(script[i].index, script[i].data);
         end else begin
            push_point(script[i].x, script[i].y, script[i].z, script[i].last,
                       script[i].typed, script[i].box);
            idle_sender(1'b0);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_pipeline();
         for (int a = 0; a < AXIS_COUNT; a++)
            if (ph == 0 || $urandom_range(0, 3) != 0)
               write_frame(AXIS_CODE[a], pick_column(ph % 4, a));
         if ($urandom_range(0, 3) == 0)
            write_frame(CSR_UNUSED, CSR_WIDTH'({$urandom, $urandom}));
         steady = (ph % 3 == 1);
         for (int n = 0; n < POINTS_PER_PHASE; n++) begin
            if (ph == 2 && n == 30) begin
               // stall the reader while single-point clouds pile up
               hold_requests++;
               for (int k = 0; k < PRESSURE_POINTS; k++)
                  push_point(pick_coord(), pick_coord(), pick_coord(), 1'b1, 1'b0, none);
            end
            if (cloud_left == 0)
               cloud_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 25);
            last = (cloud_left == 1);
            cloud_left--;
            push_point(pick_coord(), pick_coord(), pick_coord(), last, 1'b0, none);
            idle_sender(steady);
         end
      end

      drain_pipeline();
      if (mismatches == 0 && boxes_due.size() == 0) begin
         $display("rotated_point_bounding_box_top_tb passed");
      end else begin
         $display("rotated_point_bounding_box_top_tb failed");
      end
      $finish;
   end

endmodule
